### rtl/core/iutc_pkg.sv
`default_nettype none
package iutc_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 64;
  localparam int unsigned POS_W           = 40;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned EVID_W          = 41;
  localparam int unsigned SEED_W          = 32;
  localparam int unsigned REC_W           = TAG_W + 2 * POS_W;
  localparam int unsigned IN_DATA_W       = 96;
  localparam int unsigned OUT_DATA_W      = 64;
  localparam int unsigned OUT_USER_W      = 3;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_MERGE,
    ST_CLOSE,
    ST_DECIDE,
    ST_MOD,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_wr;
    logic load_ovf;
    logic run_init;
    logic scan_start;
    logic rd_en;
    logic merge;
    logic close;
    logic mod_start;
    logic mod_step;
    logic out_load;
    logic pass2;
  } dp_cmd_t;

  typedef struct packed {
    logic simple;
    logic out_free;
  } dp_status_t;

  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage
`default_nettype wire

### rtl/core/iutc_ram.sv
`default_nettype none
module iutc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/iutc_ctrl.sv
`default_nettype none
module iutc_ctrl #(
  parameter int unsigned MAX_RECORDS = iutc_pkg::MAX_RECORDS_DEF,
  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  input  wire iutc_pkg::dp_status_t st,
  output iutc_pkg::dp_cmd_t         cmd,
  output logic [AW-1:0]             waddr,
  output logic [AW-1:0]             raddr
);
  import iutc_pkg::*;

  localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);

  ctrl_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rank, rank_next;
  logic [AW-1:0] scan_idx, scan_idx_next;
  logic [4:0]    mod_cnt, mod_cnt_next;
  logic          pass2, pass2_next;
  logic [CW-1:0] last_pos;

  assign last_pos = count - 1'b1;
  assign waddr    = count[AW-1:0];
  assign raddr    = scan_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      rank     <= '0;
      scan_idx <= '0;
      mod_cnt  <= '0;
      pass2    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rank     <= rank_next;
      scan_idx <= scan_idx_next;
      mod_cnt  <= mod_cnt_next;
      pass2    <= pass2_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    rank_next     = rank;
    scan_idx_next = scan_idx;
    mod_cnt_next  = mod_cnt;
    pass2_next    = pass2;
    cmd           = '0;
    cmd.pass2     = pass2;
    in_ready      = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count < MAX_C) begin
            cmd.load_wr = 1'b1;
            count_next  = count + 1'b1;
          end else begin
            cmd.load_ovf = 1'b1;
          end
          if (in_last) begin
            cmd.run_init   = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.pass2      = 1'b0;
            pass2_next     = 1'b0;
            scan_idx_next  = '0;
            rank_next      = '0;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (CW'(scan_idx) == last_pos) begin
          state_next = ST_DRAIN;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (rank == last_pos) begin
          state_next = ST_CLOSE;
        end else begin
          rank_next      = rank + 1'b1;
          scan_idx_next  = '0;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = pass2 ? ST_OUT : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.simple) begin
          state_next = ST_OUT;
        end else begin
          cmd.mod_start = 1'b1;
          mod_cnt_next  = '0;
          state_next    = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        mod_cnt_next = mod_cnt + 1'b1;
        if (mod_cnt == 5'd31) begin
          cmd.run_init   = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.pass2      = 1'b1;
          pass2_next     = 1'b1;
          scan_idx_next  = '0;
          rank_next      = '0;
          state_next     = ST_SCAN;
        end
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          count_next   = '0;
          state_next   = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= MAX_C)
    else $error("record count beyond capacity");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> count != '0)
    else $error("scan with empty buffer");
  a_pass2_ties: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> !pass2)
    else $error("tie draw during second pass");
`endif
endmodule
`default_nettype wire

### rtl/core/iutc_datapath.sv
`default_nettype none
module iutc_datapath #(
  parameter int unsigned MAX_RECORDS = iutc_pkg::MAX_RECORDS_DEF,
  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire iutc_pkg::dp_cmd_t              cmd,
  output iutc_pkg::dp_status_t                st,
  input  wire logic [AW-1:0]                  waddr,
  input  wire logic [AW-1:0]                  raddr,
  input  wire logic [iutc_pkg::POS_W-1:0]     in_start,
  input  wire logic [iutc_pkg::POS_W-1:0]     in_end,
  input  wire logic [iutc_pkg::TAG_W-1:0]     in_tag,
  input  wire logic                           seed_we,
  input  wire logic [iutc_pkg::SEED_W-1:0]    seed,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [iutc_pkg::TAG_W-1:0]          out_tag,
  output logic [iutc_pkg::EVID_W-1:0]        out_evid,
  output logic                                out_none,
  output logic                                out_tie,
  output logic                                out_ovf
);
  import iutc_pkg::*;

  localparam int unsigned KW = REC_W + AW;
  localparam int unsigned TW = 42 + CW;

  logic [REC_W-1:0] rdata;
  logic             rd_vld;
  logic [AW-1:0]    rd_idx;
  logic [KW-1:0]    cand, prev_key, min_key;
  logic             have_prev, have_min;

  logic [TAG_W-1:0]      cur_tag, first_tag, chosen;
  logic [POS_W-1:0]      cs, ce;
  logic signed [TW-1:0]  total, best, grp_total, grp_len;
  logic                  have_group;
  logic [CW-1:0]         ntied, match;
  logic [SEED_W-1:0]     prng, quot;
  logic [CW-1:0]         rem;
  logic [CW:0]           rem_sh;
  logic                  ovf_seen;

  logic [TAG_W-1:0] m_tag;
  logic [POS_W-1:0] m_s, m_e;
  logic             new_grp;

  iutc_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram (
    .clk  (clk),
    .we   (cmd.load_wr),
    .waddr(waddr),
    .wdata({in_tag, in_start, in_end}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // sort key: tag, start, end, then buffer position to order duplicates
  assign cand = {rdata, rd_idx};
  assign {m_tag, m_s, m_e} = min_key[KW-1:AW];
  assign new_grp = !have_group || (m_tag != cur_tag);

  assign grp_len   = TW'(ce) - TW'(cs) + TW'(1);
  assign grp_total = total + grp_len;
  assign rem_sh    = {rem, quot[SEED_W-1]};

  assign st.simple   = (best <= 0) || (ntied == CW'(1));
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      have_prev <= 1'b0;
      have_min  <= 1'b0;
      prng      <= SEED_RESET;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (seed_we) begin
        prng <= seed;
      end else if (cmd.mod_start) begin
        prng <= xorshift32(prng);
      end
      if (cmd.run_init) begin
        have_prev <= 1'b0;
      end else if (cmd.merge) begin
        have_prev <= 1'b1;
      end
      if (cmd.scan_start) begin
        have_min <= 1'b0;
      end else if (rd_vld && (!have_prev || cand > prev_key) &&
                   (!have_min || cand < min_key)) begin
        have_min <= 1'b1;
      end
      if (cmd.load_ovf) begin
        ovf_seen <= 1'b1;
      end else if (cmd.out_load) begin
        ovf_seen <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= raddr;
    if (rd_vld && (!have_prev || cand > prev_key) && (!have_min || cand < min_key)) begin
      min_key <= cand;
    end
    if (cmd.merge) begin
      prev_key <= min_key;
    end

    if (cmd.run_init) begin
      have_group <= 1'b0;
      match      <= '0;
      if (!cmd.pass2) begin
        best  <= '0;
        ntied <= '0;
      end
    end

    // close a tag group: pass one ranks, pass two picks the drawn tie
    if ((cmd.merge && new_grp && have_group) || cmd.close) begin
      if (!cmd.pass2) begin
        if (grp_total > best) begin
          best      <= grp_total;
          ntied     <= CW'(1);
          first_tag <= cur_tag;
        end else if (grp_total == best && best > 0) begin
          ntied <= ntied + 1'b1;
        end
      end else if (grp_total == best) begin
        if (match == rem) begin
          chosen <= cur_tag;
        end
        match <= match + 1'b1;
      end
    end

    if (cmd.merge) begin
      if (new_grp) begin
        have_group <= 1'b1;
        cur_tag    <= m_tag;
        cs         <= m_s;
        ce         <= m_e;
        total      <= '0;
      end else if (m_s <= ce) begin
        if (m_e > ce) begin
          ce <= m_e;
        end
      end else begin
        total <= grp_total;
        cs    <= m_s;
        ce    <= m_e;
      end
    end

    // restoring remainder, one quotient bit per cycle
    if (cmd.mod_start) begin
      quot <= xorshift32(prng);
      rem  <= '0;
    end else if (cmd.mod_step) begin
      quot <= quot << 1;
      if (rem_sh >= {1'b0, ntied}) begin
        rem <= CW'(rem_sh - {1'b0, ntied});
      end else begin
        rem <= rem_sh[CW-1:0];
      end
    end

    if (cmd.out_load) begin
      out_ovf <= ovf_seen;
      if (best <= 0) begin
        out_tag  <= '0;
        out_evid <= '0;
        out_none <= 1'b1;
        out_tie  <= 1'b0;
      end else begin
        out_tag  <= (ntied == CW'(1)) ? first_tag : chosen;
        out_evid <= best[EVID_W-1:0];
        out_none <= 1'b0;
        out_tie  <= (ntied != CW'(1));
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result overwritten before transfer");
  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_none |-> out_tag == '0 && !out_tie && out_evid == '0)
    else $error("no-winner result carries data");
  a_draw_needs_tie: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> ntied > CW'(1) && best > 0)
    else $error("tie draw without tie");
`endif
endmodule
`default_nettype wire

### rtl/core/interval_union_tag_consensus.sv
`default_nettype none
// records transfer one per cycle while loading; the last record of a read starts
// the ranking, and when tags tie a second pass picks the drawn tag
// (repeated min-key scans over the single read port of the record ram)
// s_axis_tready stays low from the last record until the result register is free
// synchronous active-high reset: empty buffer, no result, generator = 1
module interval_union_tag_consensus #(
  parameter int unsigned MAX_RECORDS = iutc_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // interval_start[39:0], interval_end[79:40], record_tag[95:80]
  input  wire logic [iutc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // winner_tag[15:0], winning_evidence[56:16], zero above
  output logic [iutc_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // no_winner[0], was_tie[1], overflow[2]
  output logic [iutc_pkg::OUT_USER_W-1:0]          m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_wen,
  input  wire logic [iutc_pkg::SEED_W-1:0]         cfg_wdata
);
  import iutc_pkg::*;

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  dp_cmd_t       cmd;
  dp_status_t    st;
  logic [AW-1:0] waddr, raddr;
  logic [TAG_W-1:0]  out_tag;
  logic [EVID_W-1:0] out_evid;
  logic              out_none, out_tie, out_ovf;

  // sequencer: load, scan for next record in order, merge, decide, draw, output
  iutc_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_last (s_axis_tlast),
    .in_ready(s_axis_tready),
    .st      (st),
    .cmd     (cmd),
    .waddr   (waddr),
    .raddr   (raddr)
  );

  // record store, merge arithmetic, tie draw and result register
  iutc_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .waddr    (waddr),
    .raddr    (raddr),
    .in_start (s_axis_tdata[POS_W-1:0]),
    .in_end   (s_axis_tdata[2*POS_W-1:POS_W]),
    .in_tag   (s_axis_tdata[REC_W-1:2*POS_W]),
    .seed_we  (cfg_wen),
    .seed     (cfg_wdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_tag  (out_tag),
    .out_evid (out_evid),
    .out_none (out_none),
    .out_tie  (out_tie),
    .out_ovf  (out_ovf)
  );

  // pack result transfer, pad to whole bytes
  assign m_axis_tdata = {{(OUT_DATA_W - TAG_W - EVID_W){1'b0}}, out_evid, out_tag};
  assign m_axis_tuser = {out_ovf, out_tie, out_none};
endmodule
`default_nettype wire

### test/interval_union_tag_consensus_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module interval_union_tag_consensus_tb;
  import iutc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 200;   // block is idle soon after its last result
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  // one interval record as it travels on the slave side
  typedef struct {
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [TAG_W-1:0] tag;
    logic             fin;
  } interval_rec_t;

  // one consensus verdict per read
  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [EVID_W-1:0] evidence;
    logic              none;
    logic              tie;
    logic              ovf;
  } verdict_t;

  logic clk;
  logic rst;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_wen;
  logic [SEED_W-1:0]     cfg_wdata;

  interval_union_tag_consensus DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),   // interval_start[39:0], interval_end[79:40], record_tag[95:80]
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // winner_tag[15:0], winning_evidence[56:16]
    .m_axis_tuser (m_axis_tuser),   // no_winner[0], was_tie[1], overflow[2]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
  );

  // records waiting to be sent, and verdicts waiting to come back
  interval_rec_t pending_recs[$];
  verdict_t      awaited_verdicts[$];

  // predictor state: the buffered read and the tie-break generator
  interval_rec_t held_recs[$];
  logic          held_ovf;
  logic [SEED_W-1:0] tie_rng;

  int unsigned cyc;
  int unsigned fail_count;
  int unsigned reads_seen, ties_seen, empty_seen, ovf_seen;
  logic calm;   // long stretch with no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SEED_W-1:0] tie_rng_next(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic bit rec_before(input interval_rec_t a, input interval_rec_t b);
    if (a.tag != b.tag) return a.tag < b.tag;
    if (a.first_pos != b.first_pos) return a.first_pos < b.first_pos;
    return a.last_pos < b.last_pos;
  endfunction

  // absorb one accepted record; on the last one of a read, rank the tags
  task automatic absorb_record(input interval_rec_t r);
    interval_rec_t srt[$];
    interval_rec_t tmp;
    logic [TAG_W-1:0] tied[$];
    longint best, total, cs, ce, s, e;
    int i, j;
    logic [TAG_W-1:0] cur;
    verdict_t v;
    logic [SEED_W-1:0] pick;
    if (held_recs.size() < MAX_RECORDS_DEF) held_recs.insert(held_recs.size(), r);
    else held_ovf = 1'b1;
    if (!r.fin) return;
    srt = held_recs;
    // insertion sort by tag, then start, then end
    for (i = 1; i < srt.size(); i++) begin
      tmp = srt[i];
      j = i;
      while (j > 0 && rec_before(tmp, srt[j-1])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = tmp;
    end
    best = 0;
    i = 0;
    while (i < srt.size()) begin
      cur = srt[i].tag;
      cs = longint'(srt[i].first_pos);
      ce = longint'(srt[i].last_pos);
      total = 0;
      i++;
      while (i < srt.size() && srt[i].tag == cur) begin
        s = longint'(srt[i].first_pos);
        e = longint'(srt[i].last_pos);
        if (s <= ce) begin
          if (e > ce) ce = e;
        end else begin
          total += ce - cs + 1;
          cs = s;
          ce = e;
        end
        i++;
      end
      total += ce - cs + 1;   // lengths may be zero or negative when end < start
      if (total > best) begin
        best = total;
        tied.delete();
        tied.insert(tied.size(), cur);
      end else if (total == best && best > 0) begin
        tied.insert(tied.size(), cur);
      end
    end
    v.ovf = held_ovf;
    if (best <= 0) begin
      v.tag = '0; v.evidence = '0; v.none = 1'b1; v.tie = 1'b0;
    end else begin
      v.none = 1'b0;
      v.evidence = best[EVID_W-1:0];
      if (tied.size() == 1) begin
        v.tag = tied[0];
        v.tie = 1'b0;
      end else begin
        // tied tags are already in ascending order from the sort
        tie_rng = tie_rng_next(tie_rng);
        pick = tie_rng % SEED_W'(tied.size());
        v.tag = tied[pick];
        v.tie = 1'b1;
      end
    end
    awaited_verdicts.insert(awaited_verdicts.size(), v);
    held_recs.delete();
    held_ovf = 1'b0;
  endtask

  // sender: one transfer per handshake, random gaps outside the calm window
  always @(posedge clk) begin
    interval_rec_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        r.first_pos = s_axis_tdata[POS_W-1:0];
        r.last_pos  = s_axis_tdata[2*POS_W-1:POS_W];
        r.tag       = s_axis_tdata[IN_DATA_W-1:2*POS_W];
        r.fin       = s_axis_tlast;
        absorb_record(r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_recs.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
          r = pending_recs.pop_front();
          s_axis_tdata  <= {r.tag, r.last_pos, r.first_pos};
          s_axis_tlast  <= r.fin;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, compares each verdict with the oldest prediction
  always @(posedge clk) begin
    verdict_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict tdata=%h tuser=%b", $time, m_axis_tdata,
                   m_axis_tuser);
          fail_count++;
        end else begin
          w = awaited_verdicts.pop_front();
          reads_seen++;
          if (w.tie) ties_seen++;
          if (w.none) empty_seen++;
          if (w.ovf) ovf_seen++;
          if (m_axis_tdata[TAG_W-1:0] !== w.tag) begin
            $display("%0t: winner_tag expected %h actual %h", $time, w.tag,
                     m_axis_tdata[TAG_W-1:0]);
            fail_count++;
          end
          if (m_axis_tdata[TAG_W+EVID_W-1:TAG_W] !== w.evidence) begin
            $display("%0t: winning_evidence expected %h actual %h", $time, w.evidence,
                     m_axis_tdata[TAG_W+EVID_W-1:TAG_W]);
            fail_count++;
          end
          if (m_axis_tuser[0] !== w.none) begin
            $display("%0t: no_winner expected %b actual %b", $time, w.none, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tuser[1] !== w.tie) begin
            $display("%0t: was_tie expected %b actual %b", $time, w.tie, m_axis_tuser[1]);
            fail_count++;
          end
          if (m_axis_tuser[2] !== w.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, w.ovf, m_axis_tuser[2]);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog and calm window
  always @(posedge clk) begin
    cyc <= cyc + 1;
    calm <= (cyc >= 2000 && cyc < 8000);
    if (cyc >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, awaited_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_rec(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b,
                           input logic [TAG_W-1:0] t, input logic f);
    interval_rec_t r;
    r.first_pos = a; r.last_pos = b; r.tag = t; r.fin = f;
    pending_recs.insert(pending_recs.size(), r);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return {8'($urandom_range(255)), $urandom()};
  endfunction

  // random read: tags from a small pool so they collide, clustered positions
  // so intervals overlap, now and then reversed or randomly placed intervals
  task automatic queue_random_read(input int n);
    logic [TAG_W-1:0] tag_base;
    logic [POS_W-1:0] pos_base, a, b;
    int pool, k;
    tag_base = TAG_W'($urandom());
    pos_base = rand_pos();
    pool = $urandom_range(1, 5);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: begin a = rand_pos(); b = rand_pos(); end
        1: begin a = pos_base + $urandom_range(40); b = a - $urandom_range(5); end
        default: begin a = pos_base + $urandom_range(60); b = a + $urandom_range(30); end
      endcase
      queue_rec(a, b, TAG_W'(tag_base + $urandom_range(pool - 1)), k == n - 1);
    end
  endtask

  // read built so that several tags cover exactly the same length
  task automatic queue_tie_read(input int ntags);
    logic [TAG_W-1:0] t;
    logic [POS_W-1:0] a;
    int len, k;
    t = TAG_W'($urandom());
    len = $urandom_range(1, 50);
    for (k = 0; k < ntags; k++) begin
      a = rand_pos();
      // split one span into two overlapping pieces for every other tag
      if (k % 2 == 1) begin
        queue_rec(a, a + len / 2, TAG_W'(t + k), 1'b0);
        queue_rec(a + len / 4, a + len - 1, TAG_W'(t + k), k == ntags - 1);
      end else begin
        queue_rec(a, a + len - 1, TAG_W'(t + k), k == ntags - 1);
      end
    end
  endtask

  // sampled away from the active edge so the queues and handshakes have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_recs.size() > 0 || s_axis_tvalid || awaited_verdicts.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // seed writes only happen with nothing in flight
  task automatic load_seed(input logic [SEED_W-1:0] seed);
    wait_idle();
    cfg_wdata <= seed;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    tie_rng = seed;
  endtask

  task automatic queue_random_phase(input int records);
    int sent, n;
    sent = 0;
    while (sent < records) begin
      case ($urandom_range(19))
        0: n = $urandom_range(20, 40);
        1, 2, 3, 4: begin
          n = $urandom_range(2, 6);
          queue_tie_read(n);
          sent += n + n / 2;
          continue;
        end
        default: n = $urandom_range(1, 8);
      endcase
      queue_random_read(n);
      sent += n;
    end
  endtask

  initial begin
    int k;
    cyc = 0;
    fail_count = 0;
    reads_seen = 0; ties_seen = 0; empty_seen = 0; ovf_seen = 0;
    calm = 1'b0;
    held_ovf = 1'b0;
    tie_rng = SEED_RESET;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme positions and tags, one record reads
    queue_rec(POS_MAX, POS_MAX, TAG_MAX, 1'b1);
    queue_rec('0, POS_MAX, '0, 1'b1);                 // widest possible evidence
    queue_rec('0, '0, 16'h0001, 1'b1);
    // reversed intervals only: no positive evidence anywhere
    queue_rec(40'd100, 40'd50, 16'h0007, 1'b0);
    queue_rec(40'd10, 40'd9, 16'h0008, 1'b1);
    // negative piece pulls a tag below a rival
    queue_rec(40'd0, 40'd9, 16'h0010, 1'b0);
    queue_rec(40'd20, 40'd10, 16'h0010, 1'b0);
    queue_rec(40'd0, 40'd4, 16'h0011, 1'b1);
    // nested and touching intervals within one tag, plus a three-way tie
    queue_rec(40'd0, 40'd99, 16'h0020, 1'b0);
    queue_rec(40'd10, 40'd20, 16'h0020, 1'b0);
    queue_rec(40'd99, 40'd149, 16'h0020, 1'b0);
    queue_rec(40'd500, 40'd649, 16'h0021, 1'b0);
    queue_rec(40'd7, 40'd156, 16'hFFFF, 1'b1);
    wait_idle();   // queue nothing more until every verdict is back

    // buffer full: records past capacity dropped, the dropped last still ends the read
    for (k = 0; k < MAX_RECORDS_DEF + 2; k++)
      queue_rec(rand_pos(), rand_pos(), TAG_W'($urandom_range(3)), k == MAX_RECORDS_DEF + 1);
    // exactly full, no overflow
    for (k = 0; k < MAX_RECORDS_DEF; k++)
      queue_rec(40'd5 * k, 40'd5 * k + 3, TAG_W'(k % 4), k == MAX_RECORDS_DEF - 1);
    queue_random_phase(300);

    load_seed('1);
    queue_tie_read(4);
    queue_random_phase(300);
    load_seed('0);                                    // generator stuck at zero
    queue_tie_read(3);
    queue_random_phase(250);
    load_seed(32'h8000_0000);
    queue_random_phase(250);
    load_seed($urandom());
    queue_random_phase(300);
    wait_idle();

    $display("reads checked: %0d, tie-breaks: %0d, no-winner reads: %0d, overflowed reads: %0d",
             reads_seen, ties_seen, empty_seen, ovf_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
